// ----- rtl/kvcl_pkg.sv -----
// Shared types, codes and helpers for the key/value config lexer.
package kvcl_pkg;

   // result kinds
   localparam logic [2:0] KIND_NAME  = 3'd0;
   localparam logic [2:0] KIND_VALUE = 3'd1;
   localparam logic [2:0] KIND_PAIR  = 3'd2;
   localparam logic [2:0] KIND_ERROR = 3'd3;
   localparam logic [2:0] KIND_END   = 3'd4;

   // error codes
   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_EXPECT_EQ   = 3'd1;
   localparam logic [2:0] ERR_EXPECT_NL   = 3'd2;
   localparam logic [2:0] ERR_EOF_VALUE   = 3'd3;
   localparam logic [2:0] ERR_EOF_MULTI   = 3'd4;
   localparam logic [2:0] ERR_EOF_COMMENT = 3'd5;
   localparam logic [2:0] ERR_OVERFLOW    = 3'd6;

   // characters
   localparam logic [7:0] CH_LT   = 8'h3C;
   localparam logic [7:0] CH_QM   = 8'h3F;
   localparam logic [7:0] CH_GT   = 8'h3E;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_EQ   = 8'h3D;
   localparam logic [7:0] CH_SP   = 8'h20;
   localparam logic [7:0] CH_TAB  = 8'h09;
   localparam logic [7:0] CH_NL   = 8'h0A;

   localparam logic [31:0] POS_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [2:0]  out_kind;
      logic [7:0]  out_byte;
      logic [2:0]  error_code;
      logic [31:0] line_number;
      logic [31:0] column_number;
      logic        last_of_run;
   } rsp_type;

   // one result without the end-of-run flag
   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  data;
      logic [2:0]  code;
      logic [31:0] line;
      logic [31:0] column;
   } tok_type;

   // work handed from the lexer to the result sequencer for one word
   typedef struct packed {
      logic       push;      // hold back one blank
      logic       push_tab;  // held blank is a tab
      logic [1:0] nres;      // direct results after any flush
      tok_type    r0;
      tok_type    r1;
   } cmd_type;

   function automatic tok_type mk_tok(logic [2:0] k, logic [7:0] b, logic [2:0] e,
                                      logic [31:0] ln, logic [31:0] cl);
      tok_type t;
      t.kind   = k;
      t.data   = b;
      t.code   = e;
      t.line   = ln;
      t.column = cl;
      return t;
   endfunction

   function automatic logic [31:0] sat_inc(logic [31:0] v);
      return (v == POS_MAX) ? POS_MAX : v + 32'd1;
   endfunction

endpackage

// ----- rtl/kvcl_front.sv -----
// Lexer front end: classifies each text byte, tracks position, builds result commands.
module kvcl_front
   import kvcl_pkg::*;
#(
   parameter int PENDING_DEPTH = 32,
   parameter int CW = $clog2(PENDING_DEPTH + 1),
   parameter int IW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  req_type       req,
   output logic          cmd_valid,
   output cmd_type       cmd,
   output logic [CW-1:0] cmd_flush,
   output logic [IW-1:0] cmd_idx
);

   localparam logic [3:0] M_LINE_START   = 4'd0;
   localparam logic [3:0] M_LINE_WS      = 4'd1;
   localparam logic [3:0] M_NAME         = 4'd2;
   localparam logic [3:0] M_AFTER_NAME   = 4'd3;
   localparam logic [3:0] M_BEFORE_VALUE = 4'd4;
   localparam logic [3:0] M_VALUE        = 4'd5;
   localparam logic [3:0] M_LT_SEEN      = 4'd6;
   localparam logic [3:0] M_MULTI        = 4'd7;
   localparam logic [3:0] M_MULTI_Q      = 4'd8;
   localparam logic [3:0] M_AFTER_MULTI  = 4'd9;
   localparam logic [3:0] M_COMMENT      = 4'd10;
   localparam logic [3:0] M_ERROR        = 4'd11;

   logic [3:0]    mode_ff, mode_in;
   logic [31:0]   line_ff, line_in;
   logic [31:0]   col_ff, col_in;
   logic [31:0]   sline_ff, sline_in;
   logic [31:0]   scol_ff, scol_in;
   logic [CW-1:0] pcnt_ff, pcnt_in;

   logic       eoi;
   logic [7:0] c;
   logic       blank;
   logic       namec;
   logic       sl_go;
   logic       sl_emit;
   tok_type    sl_tok;

   always_comb begin
      eoi   = req.end_of_input | (req.in_byte == 8'd0);
      c     = eoi ? 8'd0 : req.in_byte;
      blank = (c == CH_SP) | (c == CH_TAB);
      namec = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
              ((c >= 8'h30) && (c <= 8'h39)) || (c == 8'h2D) || (c == 8'h5F);

      mode_in  = mode_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      sline_in = sline_ff;
      scol_in  = scol_ff;
      pcnt_in  = pcnt_ff;

      cmd          = '0;
      cmd.push_tab = (c == CH_TAB);
      cmd_flush    = '0;
      sl_go        = 1'b0;
      sl_emit      = 1'b0;
      sl_tok       = '0;

      case (mode_ff)
         M_LINE_START, M_LINE_WS: begin
            if (eoi) begin
               cmd.nres = 2'd1;
               if (mode_ff == M_LINE_START) begin
                  cmd.r0 = mk_tok(KIND_END, 8'd0, ERR_NONE, 32'd0, 32'd0);
               end else begin
                  cmd.r0  = mk_tok(KIND_ERROR, 8'd0, ERR_EXPECT_NL, line_ff, col_ff);
                  mode_in = M_ERROR;
               end
            end else if (blank) begin
               mode_in = M_LINE_WS;
            end else if (namec) begin
               cmd.r0   = mk_tok(KIND_NAME, c, ERR_NONE, 32'd0, 32'd0);
               cmd.nres = 2'd1;
               mode_in  = M_NAME;
            end else if (c == CH_HASH) begin
               mode_in = M_COMMENT;
            end else if (c == CH_NL) begin
               mode_in = M_LINE_START;
            end else begin
               cmd.r0   = mk_tok(KIND_ERROR, c, ERR_EXPECT_NL, line_ff, col_ff);
               cmd.nres = 2'd1;
               mode_in  = M_ERROR;
            end
         end
         M_NAME, M_AFTER_NAME: begin
            if (!eoi && namec && (mode_ff == M_NAME)) begin
               cmd.r0   = mk_tok(KIND_NAME, c, ERR_NONE, 32'd0, 32'd0);
               cmd.nres = 2'd1;
            end else if (!eoi && blank) begin
               mode_in = M_AFTER_NAME;
            end else if (!eoi && (c == CH_EQ)) begin
               mode_in = M_BEFORE_VALUE;
            end else begin
               cmd.r0   = mk_tok(KIND_ERROR, c, ERR_EXPECT_EQ, line_ff, col_ff);
               cmd.nres = 2'd1;
               mode_in  = M_ERROR;
            end
         end
         M_BEFORE_VALUE: begin
            if (!eoi && blank) begin
               mode_in = M_BEFORE_VALUE;
            end else if (!eoi && (c == CH_LT)) begin
               mode_in = M_LT_SEEN;
            end else begin
               sl_go = 1'b1;
            end
         end
         M_VALUE: begin
            sl_go = 1'b1;
         end
         M_LT_SEEN: begin
            if (!eoi && (c == CH_QM)) begin
               sline_in = line_ff;
               scol_in  = sat_inc(col_ff);
               mode_in  = M_MULTI;
            end else begin
               // lone '<' is plain value text
               cmd.r0   = mk_tok(KIND_VALUE, CH_LT, ERR_NONE, 32'd0, 32'd0);
               cmd.nres = 2'd1;
               sl_go    = 1'b1;
            end
         end
         M_MULTI: begin
            if (eoi) begin
               cmd.r0   = mk_tok(KIND_ERROR, 8'd0, ERR_EOF_MULTI, sline_ff, scol_ff);
               cmd.nres = 2'd1;
               mode_in  = M_ERROR;
            end else if (c == CH_QM) begin
               mode_in = M_MULTI_Q;
            end else begin
               cmd.r0   = mk_tok(KIND_VALUE, c, ERR_NONE, 32'd0, 32'd0);
               cmd.nres = 2'd1;
            end
         end
         M_MULTI_Q: begin
            if (!eoi && (c == CH_GT)) begin
               cmd.r0   = mk_tok(KIND_PAIR, 8'd0, ERR_NONE, 32'd0, 32'd0);
               cmd.nres = 2'd1;
               mode_in  = M_AFTER_MULTI;
            end else if (eoi) begin
               cmd.r0   = mk_tok(KIND_ERROR, 8'd0, ERR_EOF_MULTI, sline_ff, scol_ff);
               cmd.nres = 2'd1;
               mode_in  = M_ERROR;
            end else begin
               // lone '?' is plain value text; a second '?' may still close
               cmd.r0   = mk_tok(KIND_VALUE, CH_QM, ERR_NONE, 32'd0, 32'd0);
               cmd.nres = 2'd1;
               if (c == CH_QM) begin
                  mode_in = M_MULTI_Q;
               end else begin
                  cmd.r1   = mk_tok(KIND_VALUE, c, ERR_NONE, 32'd0, 32'd0);
                  cmd.nres = 2'd2;
                  mode_in  = M_MULTI;
               end
            end
         end
         M_AFTER_MULTI: begin
            if (!eoi && blank) begin
               mode_in = M_AFTER_MULTI;
            end else if (!eoi && (c == CH_HASH)) begin
               mode_in = M_COMMENT;
            end else if (!eoi && (c == CH_NL)) begin
               mode_in = M_LINE_START;
            end else begin
               cmd.r0   = mk_tok(KIND_ERROR, c, ERR_EXPECT_NL, line_ff, col_ff);
               cmd.nres = 2'd1;
               mode_in  = M_ERROR;
            end
         end
         M_COMMENT: begin
            if (eoi) begin
               cmd.r0   = mk_tok(KIND_ERROR, 8'd0, ERR_EOF_COMMENT, line_ff, col_ff);
               cmd.nres = 2'd1;
               mode_in  = M_ERROR;
            end else if (c == CH_NL) begin
               mode_in = M_LINE_START;
            end
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase

      // single-line value byte, possibly after a lone '<'
      if (sl_go) begin
         mode_in = M_VALUE;
         if (eoi) begin
            sl_emit = 1'b1;
            sl_tok  = mk_tok(KIND_ERROR, 8'd0, ERR_EOF_VALUE, line_ff, col_ff);
            mode_in = M_ERROR;
         end else if (blank) begin
            if (pcnt_ff >= CW'(PENDING_DEPTH)) begin
               sl_emit = 1'b1;
               sl_tok  = mk_tok(KIND_ERROR, c, ERR_OVERFLOW, line_ff, col_ff);
               mode_in = M_ERROR;
            end else begin
               cmd.push = 1'b1;
               pcnt_in  = pcnt_ff + CW'(1);
            end
         end else if ((c == CH_NL) || (c == CH_HASH)) begin
            // trailing blanks are dropped
            pcnt_in = '0;
            sl_emit = 1'b1;
            sl_tok  = mk_tok(KIND_PAIR, 8'd0, ERR_NONE, 32'd0, 32'd0);
            mode_in = (c == CH_NL) ? M_LINE_START : M_COMMENT;
         end else begin
            cmd_flush = pcnt_ff;
            pcnt_in   = '0;
            sl_emit   = 1'b1;
            sl_tok    = mk_tok(KIND_VALUE, c, ERR_NONE, 32'd0, 32'd0);
         end
         if (sl_emit) begin
            if (cmd.nres == 2'd0) begin
               cmd.r0 = sl_tok;
            end else begin
               cmd.r1 = sl_tok;
            end
            cmd.nres = cmd.nres + 2'd1;
         end
      end

      if (eoi) begin
         mode_in  = M_LINE_START;
         line_in  = 32'd1;
         col_in   = 32'd1;
         sline_in = 32'd1;
         scol_in  = 32'd1;
         pcnt_in  = '0;
      end else if (mode_in != M_ERROR) begin
         if (c == CH_NL) begin
            line_in = sat_inc(line_ff);
            col_in  = 32'd1;
         end else begin
            col_in = sat_inc(col_ff);
         end
      end
   end

   assign cmd_idx   = pcnt_ff[IW-1:0];
   assign cmd_valid = accept && (cmd.push || (cmd.nres != 2'd0));

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_LINE_START;
         line_ff  <= 32'd1;
         col_ff   <= 32'd1;
         sline_ff <= 32'd1;
         scol_ff  <= 32'd1;
         pcnt_ff  <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         sline_ff <= sline_in;
         scol_ff  <= scol_in;
         pcnt_ff  <= pcnt_in;
      end
   end

endmodule

// ----- rtl/kvcl_cmd_fifo.sv -----
// Short command queue between the lexer front end and the result sequencer.
module kvcl_cmd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             full,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    cnt_ff, cnt_in;
   logic             do_wr, do_rd;

   assign full    = (cnt_ff == NW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + NW'(1);
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ----- rtl/kvcl_back.sv -----
// Result sequencer: holds back blanks, flushes them, emits results into the output register.
module kvcl_back
   import kvcl_pkg::*;
#(
   parameter int PENDING_DEPTH = 32,
   parameter int CW = $clog2(PENDING_DEPTH + 1),
   parameter int IW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          cmd_valid,
   input  cmd_type       cmd,
   input  logic [CW-1:0] cmd_flush,
   input  logic [IW-1:0] cmd_idx,
   output logic          cmd_deq,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output rsp_type       rsp_word
);

   localparam int SW = $clog2(PENDING_DEPTH + 3);

   // held-back blanks, 1 = tab; flushed from bit 0 by shifting right
   logic [PENDING_DEPTH-1:0] pend_ff, pend_in;
   logic [SW-1:0]            step_ff, step_in;
   logic                     outv_ff, outv_in;
   rsp_type                  out_ff, out_in;

   logic          zero;
   logic          slot_free;
   logic          fire;
   logic          in_flush;
   logic          last;
   logic          wr;
   logic [SW-1:0] fl;
   logic [SW-1:0] tot;
   tok_type       tok;

   always_comb begin
      fl        = SW'(cmd_flush);
      tot       = fl + SW'(cmd.nres);
      zero      = (cmd.nres == 2'd0);
      slot_free = !outv_ff || rsp_pop;
      fire      = cmd_valid && !zero && slot_free;
      in_flush  = (step_ff < fl);
      last      = ((step_ff + SW'(1)) == tot);
      cmd_deq   = (cmd_valid && zero) || (fire && last);
      wr        = cmd.push && ((cmd_valid && zero) || (fire && (step_ff == '0)));

      if (in_flush) begin
         tok = mk_tok(KIND_VALUE, pend_ff[0] ? CH_TAB : CH_SP, ERR_NONE, 32'd0, 32'd0);
      end else if (step_ff == fl) begin
         tok = cmd.r0;
      end else begin
         tok = cmd.r1;
      end

      pend_in = pend_ff;
      if (fire && in_flush) begin
         pend_in = pend_ff >> 1;
      end
      if (wr) begin
         pend_in[cmd_idx] = cmd.push_tab;
      end

      step_in = step_ff;
      if (fire) begin
         step_in = last ? '0 : step_ff + SW'(1);
      end

      out_in               = out_ff;
      out_in.out_kind      = tok.kind;
      out_in.out_byte      = tok.data;
      out_in.error_code    = tok.code;
      out_in.line_number   = tok.line;
      out_in.column_number = tok.column;
      out_in.last_of_run   = last;

      if (fire) begin
         outv_in = 1'b1;
      end else if (rsp_pop) begin
         outv_in = 1'b0;
      end else begin
         outv_in = outv_ff;
      end
   end

   assign rsp_empty = !outv_ff;
   assign rsp_word  = out_ff;

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (fire) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         outv_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         outv_ff <= outv_in;
      end
   end

endmodule

// ----- rtl/key_value_config_lexer.sv -----
// The first result word of a text byte passes the command queue, then the output register.
// Throughput: one byte per cycle while full is low; the sequencer emits the k results of a byte
//   one at a time, up to PENDING_DEPTH + 1 when held-back blanks flush, and full rises once
//   the command queue between lexer and sequencer fills.
// Reset: synchronous, active high; clears lexer state, queue, sequencer step and output valid flag.
//   The blank store is not cleared and needs no clearing pass.
module key_value_config_lexer
   import kvcl_pkg::*;
#(
   parameter int PENDING_DEPTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_word,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_word
);

   localparam int CW        = $clog2(PENDING_DEPTH + 1);
   localparam int IW        = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam int QW        = $bits(cmd_type) + CW + IW;
   localparam int CMD_DEPTH = 4;

   logic          accept;
   logic          f_valid;
   cmd_type       f_cmd;
   logic [CW-1:0] f_flush;
   logic [IW-1:0] f_idx;

   logic [QW-1:0] q_data;
   logic          q_empty;
   logic          q_deq;
   cmd_type       b_cmd;
   logic [CW-1:0] b_flush;
   logic [IW-1:0] b_idx;

   assign accept                   = push && !full;
   assign {b_cmd, b_flush, b_idx}  = q_data;

   kvcl_front #(
      .PENDING_DEPTH(PENDING_DEPTH),
      .CW(CW),
      .IW(IW)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_word),
      .cmd_valid(f_valid),
      .cmd      (f_cmd),
      .cmd_flush(f_flush),
      .cmd_idx  (f_idx)
   );

   kvcl_cmd_fifo #(
      .WIDTH(QW),
      .DEPTH(CMD_DEPTH)
   ) u_fifo (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (f_valid),
      .wr_data({f_cmd, f_flush, f_idx}),
      .rd_en  (q_deq),
      .rd_data(q_data),
      .full   (full),
      .empty  (q_empty)
   );

   kvcl_back #(
      .PENDING_DEPTH(PENDING_DEPTH),
      .CW(CW),
      .IW(IW)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_valid(!q_empty),
      .cmd      (b_cmd),
      .cmd_flush(b_flush),
      .cmd_idx  (b_idx),
      .cmd_deq  (q_deq),
      .rsp_empty(empty),
      .rsp_pop  (pop),
      .rsp_word (rsp_word)
   );

endmodule

// ----- rtl/kvcl_checker.sv -----
// Port-level checks for the key/value config lexer, bound to the top level.
module kvcl_checker
   import kvcl_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    full,
   input logic    empty,
   input logic    pop,
   input rsp_type rsp_word
);

   // reset leaves nothing queued or waiting
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("words left after reset");

   // only errors carry a code and a position
   a_plain_clean: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_word.out_kind != KIND_ERROR)) |->
      ((rsp_word.error_code == ERR_NONE) && (rsp_word.line_number == 32'd0) &&
       (rsp_word.column_number == 32'd0)))
      else $error("non-error word with code or position");

   // an error ends its run and points at a real position
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_word.out_kind == KIND_ERROR)) |->
      (rsp_word.last_of_run && (rsp_word.error_code != ERR_NONE) &&
       (rsp_word.line_number != 32'd0) && (rsp_word.column_number != 32'd0)))
      else $error("bad error word");

   // clean end is alone and empty
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_word.out_kind == KIND_END)) |->
      (rsp_word.last_of_run && (rsp_word.out_byte == 8'd0)))
      else $error("bad clean end word");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_word)))
      else $error("result word changed while waiting");

endmodule

bind key_value_config_lexer kvcl_checker u_checker (.*);
